### hdl/ptc_pkg.sv
// Shared constants, codes and controller/datapath interface types for the tree counter.
package ptc_pkg;

    // Sizing
    localparam int MAX_TAXA    = 16;
    localparam int COUNT_WIDTH = 64;

    // Port field widths
    localparam int CMD_W    = 3;
    localparam int TAXA_W   = 5;
    localparam int NODES_W  = 4;
    localparam int TREE_W   = 64;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int IDX_W   = $clog2(MAX_TAXA);
    localparam int MUL_W   = $clog2(2 * MAX_TAXA);
    localparam int PROD_W  = COUNT_WIDTH + MUL_W;
    localparam int ENTRY_W = COUNT_WIDTH + 1;

    // Divider: DIV_STEP quotient bits per cycle
    localparam int DIV_STEP  = 4;
    localparam int DIV_CYC   = (COUNT_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_LEN   = DIV_CYC * DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_CYC);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROOTED            = 3'd0,
        CMD_RESOLVED_ROOTED   = 3'd1,
        CMD_UNROOTED          = 3'd2,
        CMD_RESOLVED_UNROOTED = 3'd3,
        CMD_TOTAL_ROOTED      = 3'd4,
        CMD_TOTAL_UNROOTED    = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic latch_in;
        logic res_invalid;
        logic res_two;
        logic scratch;
        logic plan_up;
        logic plan_dn;
        logic up_init;
        logic dn_init;
        logic rd_row;
        logic mul;
        logic up_add;
        logic div_start;
        logic dn_wr;
        logic fin;
        logic res_total;
        logic qry_rd;
        logic res_entry;
        logic push;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic invalid;
        logic rn_two;
        logic scratch;
        logic rn_hit;
        logic go_up;
        logic dn_any;
        logic up_more;
        logic dn_more;
        logic idx_zero;
        logic div_done;
    } t_dp_stat;

endpackage

### hdl/ptc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ptc_div.sv
// Radix-16 restoring divider: wide count by a small row index.
module ptc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ptc_pkg::COUNT_WIDTH-1:0] i_dividend,
    input  logic [ptc_pkg::IDX_W-1:0]       i_divisor,
    output logic                            o_done,
    output logic [ptc_pkg::COUNT_WIDTH-1:0] o_quotient
);
    import ptc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_LEN-1:0]   r_quo;
    logic [IDX_W-1:0]     r_rem;
    logic [IDX_W-1:0]     r_div;
    logic [DIV_LEN-1:0]   n_quo;
    logic [IDX_W-1:0]     n_rem;
    logic [IDX_W:0]       trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int j = 0; j < DIV_STEP; j++) begin
            trial = {n_rem, n_quo[DIV_LEN-1]};
            n_quo = {n_quo[DIV_LEN-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_CYC - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - DIV_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIV_LEN'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[COUNT_WIDTH-1:0];

endmodule

### hdl/ptc_dp.sv
// Datapath: query decode, count table, saturating multiply-add, inverse step, result registers.
module ptc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptc_pkg::t_dp_cmd              i_cmd,
    output ptc_pkg::t_dp_stat             o_stat,
    input  logic [ptc_pkg::CMD_W-1:0]     i_command,
    input  logic [ptc_pkg::TAXA_W-1:0]    i_taxa,
    input  logic [ptc_pkg::NODES_W-1:0]   i_internal_nodes,
    output logic [ptc_pkg::TREE_W-1:0]    o_tree_count,
    output logic [ptc_pkg::STATUS_W-1:0]  o_status
);
    import ptc_pkg::*;

    // Latched query
    t_cmd               r_cmd;
    logic [TAXA_W-1:0]  r_taxa;
    logic [NODES_W-1:0] r_nodes;

    // Table control
    logic [TAXA_W-1:0]  r_cur;
    logic [TAXA_W-1:0]  r_k;
    logic [IDX_W-1:0]   r_m;
    logic               r_up;

    // Row pipeline
    logic [COUNT_WIDTH-1:0] r_a;
    logic                   r_am;
    logic [COUNT_WIDTH-1:0] r_b;
    logic                   r_bm;
    logic [PROD_W-1:0]      r_pa;
    logic [PROD_W-1:0]      r_pb;
    logic                   r_pbm;
    logic [COUNT_WIDTH-1:0] r_c;
    logic                   r_cm;
    logic [COUNT_WIDTH-1:0] r_tot;
    logic                   r_tmark;

    // Results
    logic [COUNT_WIDTH-1:0] r_res_count;
    t_status                r_res_status;
    logic [TREE_W-1:0]      r_out_count;
    t_status                r_out_status;

    // Decode
    logic              unrooted;
    logic              per_node;
    logic              resolved;
    logic              known;
    logic              n_ok;
    logic              args_ok;
    logic [TAXA_W-1:0] rn;
    logic [IDX_W-1:0]  idx;

    assign unrooted = (r_cmd == CMD_UNROOTED) || (r_cmd == CMD_RESOLVED_UNROOTED)
                   || (r_cmd == CMD_TOTAL_UNROOTED);
    assign per_node = (r_cmd == CMD_ROOTED) || (r_cmd == CMD_UNROOTED);
    assign resolved = (r_cmd == CMD_RESOLVED_ROOTED) || (r_cmd == CMD_RESOLVED_UNROOTED);
    assign known    = per_node || resolved || (r_cmd == CMD_TOTAL_ROOTED)
                   || (r_cmd == CMD_TOTAL_UNROOTED);
    assign rn       = unrooted ? ((r_taxa != '0) ? r_taxa - TAXA_W'(1) : '0) : r_taxa;
    assign n_ok     = unrooted ? (r_taxa >= TAXA_W'(3)) : (r_taxa >= TAXA_W'(2));
    assign args_ok  = known && n_ok && (int'(rn) <= MAX_TAXA)
                   && (!per_node || ((r_nodes != '0) && (TAXA_W'(r_nodes) < rn)));
    assign idx      = per_node ? IDX_W'(r_nodes)
                    : resolved ? IDX_W'(rn - TAXA_W'(1)) : '0;

    // Table memory: {mark, count} per row
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic                   rd_mark;

    // Arithmetic
    logic [MUL_W-1:0]       mult_k;
    logic [PROD_W-1:0]      prod_a;
    logic [PROD_W-1:0]      prod_b;
    logic                   inner_row;
    logic [PROD_W:0]        up_sum;
    logic                   up_of;
    logic [COUNT_WIDTH-1:0] up_c;
    logic                   up_cm;
    logic                   p_of;
    logic                   diff_ok;
    logic [COUNT_WIDTH-1:0] dividend;
    logic [COUNT_WIDTH:0]   tsum;
    logic                   div_done;
    logic [COUNT_WIDTH-1:0] quot;

    assign rd_count  = ram_rdata[COUNT_WIDTH-1:0];
    assign rd_mark   = ram_rdata[COUNT_WIDTH];

    // k + m - 2 serves both directions
    assign mult_k    = MUL_W'(r_k) + MUL_W'(r_m) - MUL_W'(2);
    assign prod_a    = PROD_W'(r_a) * PROD_W'(mult_k);
    assign prod_b    = PROD_W'(rd_count) * PROD_W'(r_m);
    assign inner_row = (int'(r_m) + 1) < int'(r_k);

    assign up_sum    = (PROD_W + 1)'(r_pa) + (PROD_W + 1)'(r_pb);
    assign up_of     = up_sum > (PROD_W + 1)'(COUNT_MAX);
    assign up_c      = up_of ? COUNT_MAX : up_sum[COUNT_WIDTH-1:0];
    assign up_cm     = r_am || r_pbm || up_of;

    assign p_of      = |r_pa[PROD_W-1:COUNT_WIDTH];
    assign diff_ok   = !p_of && (r_b >= r_pa[COUNT_WIDTH-1:0]);
    assign dividend  = diff_ok ? (r_b - r_pa[COUNT_WIDTH-1:0]) : '0;

    assign tsum      = {1'b0, r_tot} + {1'b0, r_c};

    always_comb begin
        ram_we    = i_cmd.up_init || i_cmd.dn_init || i_cmd.up_add || i_cmd.dn_wr;
        ram_waddr = (i_cmd.up_init || i_cmd.dn_init) ? IDX_W'(1) : r_m;
        if (i_cmd.up_add) begin
            ram_wdata = {up_cm, up_c};
        end else if (i_cmd.dn_wr) begin
            ram_wdata = {1'b0, quot};
        end else begin
            ram_wdata = {1'b0, COUNT_WIDTH'(1)};
        end
        ram_re    = i_cmd.rd_row || i_cmd.qry_rd;
        ram_raddr = i_cmd.qry_rd ? idx : r_m;
    end

    ptc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TAXA)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ptc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_m),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    // Control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_up    <= 1'b0;
            r_tmark <= 1'b0;
        end else begin
            if (i_cmd.scratch) begin
                r_cur <= TAXA_W'(2);
            end else if (i_cmd.fin) begin
                r_cur <= r_up ? r_k : r_k - TAXA_W'(1);
            end
            if (i_cmd.plan_up) begin
                r_up <= 1'b1;
            end else if (i_cmd.plan_dn) begin
                r_up <= 1'b0;
            end
            if (i_cmd.up_init || i_cmd.dn_init) begin
                r_tmark <= 1'b0;
            end else if (i_cmd.rd_row || i_cmd.fin) begin
                r_tmark <= r_tmark || tsum[COUNT_WIDTH] || r_cm;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd   <= t_cmd'(i_command);
            r_taxa  <= i_taxa;
            r_nodes <= i_internal_nodes;
        end

        if (i_cmd.plan_up) begin
            r_k <= r_cur + TAXA_W'(1);
        end else if (i_cmd.plan_dn) begin
            r_k <= r_cur;
        end

        if (i_cmd.up_init || i_cmd.dn_init) begin
            r_a   <= COUNT_WIDTH'(1);
            r_am  <= 1'b0;
            r_m   <= IDX_W'(2);
            r_tot <= COUNT_WIDTH'(1);
            r_c   <= '0;
            r_cm  <= 1'b0;
        end else if (i_cmd.up_add) begin
            r_c   <= up_c;
            r_cm  <= up_cm;
            r_a   <= r_b;
            r_am  <= r_bm;
            r_m   <= r_m + IDX_W'(1);
        end else if (i_cmd.dn_wr) begin
            r_c   <= quot;
            r_cm  <= 1'b0;
            r_a   <= quot;
            r_m   <= r_m + IDX_W'(1);
        end else if (i_cmd.rd_row || i_cmd.fin) begin
            r_tot <= tsum[COUNT_WIDTH] ? COUNT_MAX : tsum[COUNT_WIDTH-1:0];
        end

        if (i_cmd.mul) begin
            r_pa <= prod_a;
            r_b  <= rd_count;
            r_bm <= rd_mark;
            if (inner_row) begin
                r_pb  <= prod_b;
                r_pbm <= rd_mark;
            end else begin
                r_pb  <= '0;
                r_pbm <= 1'b0;
            end
        end

        if (i_cmd.res_invalid) begin
            r_res_count  <= '0;
            r_res_status <= ST_INVALID;
        end else if (i_cmd.res_two) begin
            r_res_count  <= COUNT_WIDTH'(1);
            r_res_status <= ST_OK;
        end else if (i_cmd.res_total) begin
            r_res_count  <= r_tmark ? COUNT_MAX : r_tot;
            r_res_status <= r_tmark ? ST_SATURATED : ST_OK;
        end else if (i_cmd.res_entry) begin
            r_res_count  <= rd_mark ? COUNT_MAX : rd_count;
            r_res_status <= rd_mark ? ST_SATURATED : ST_OK;
        end

        if (i_cmd.push) begin
            r_out_count  <= TREE_W'(r_res_count);
            r_out_status <= r_res_status;
        end
    end

    always_comb begin
        o_stat.invalid  = !args_ok;
        o_stat.rn_two   = rn == TAXA_W'(2);
        o_stat.scratch  = (r_cur < TAXA_W'(3)) || (int'(r_cur) > MAX_TAXA)
                       || ((r_cur > rn) && r_tmark);
        o_stat.rn_hit   = r_cur == rn;
        o_stat.go_up    = r_cur < rn;
        o_stat.dn_any   = int'(r_k) > 3;
        o_stat.up_more  = inner_row;
        o_stat.dn_more  = (int'(r_m) + 2) < int'(r_k);
        o_stat.idx_zero = idx == '0;
        o_stat.div_done = div_done;
    end

    assign o_tree_count = r_out_count;
    assign o_status     = r_out_status;

endmodule

### hdl/ptc_ctrl.sv
// Controller: sequences decode, table rebuild steps, query read and result handoff.
module ptc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  ptc_pkg::t_dp_stat  i_stat,
    output ptc_pkg::t_dp_cmd   o_cmd
);
    import ptc_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_DECODE  = 16'h0002,
        S_PLAN    = 16'h0004,
        S_UP_INIT = 16'h0008,
        S_UP_RD   = 16'h0010,
        S_UP_MUL  = 16'h0020,
        S_UP_ADD  = 16'h0040,
        S_DN_INIT = 16'h0080,
        S_DN_RD   = 16'h0100,
        S_DN_MUL  = 16'h0200,
        S_DN_SUB  = 16'h0400,
        S_DN_DIV  = 16'h0800,
        S_FIN     = 16'h1000,
        S_QRY     = 16'h2000,
        S_QRY_RD  = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   push;

    assign push = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.invalid) begin
                    o_cmd.res_invalid = 1'b1;
                    n_state           = S_DONE;
                end else if (i_stat.rn_two) begin
                    o_cmd.res_two = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.scratch = i_stat.scratch;
                    n_state       = S_PLAN;
                end
            end
            S_PLAN: begin
                if (i_stat.rn_hit) begin
                    n_state = S_QRY;
                end else if (i_stat.go_up) begin
                    o_cmd.plan_up = 1'b1;
                    n_state       = S_UP_INIT;
                end else begin
                    o_cmd.plan_dn = 1'b1;
                    n_state       = S_DN_INIT;
                end
            end
            S_UP_INIT: begin
                o_cmd.up_init = 1'b1;
                n_state       = S_UP_RD;
            end
            S_UP_RD: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_UP_MUL;
            end
            S_UP_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UP_ADD;
            end
            S_UP_ADD: begin
                o_cmd.up_add = 1'b1;
                n_state      = i_stat.up_more ? S_UP_RD : S_FIN;
            end
            S_DN_INIT: begin
                o_cmd.dn_init = 1'b1;
                n_state       = i_stat.dn_any ? S_DN_RD : S_FIN;
            end
            S_DN_RD: begin
                o_cmd.rd_row = 1'b1;
                n_state      = S_DN_MUL;
            end
            S_DN_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DN_SUB;
            end
            S_DN_SUB: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DN_DIV;
            end
            S_DN_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.dn_wr = 1'b1;
                    n_state     = i_stat.dn_more ? S_DN_RD : S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_PLAN;
            end
            S_QRY: begin
                if (i_stat.idx_zero) begin
                    o_cmd.res_total = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.qry_rd = 1'b1;
                    n_state      = S_QRY_RD;
                end
            end
            S_QRY_RD: begin
                o_cmd.res_entry = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (push) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

### hdl/phylogenetic_tree_counter_core.sv
// Top level of the phylogenetic tree counter: controller plus datapath.
//
//   channel   dir   handshake                   payload
//   -------   ---   -------------------------   ------------------------------------------
//   query     in    i_in_valid / o_in_ready     i_command, i_taxa, i_internal_nodes
//   result    out   o_out_valid / i_out_ready   o_tree_count, o_status
//
// A query whose rooted taxon count matches the table already built is answered
// straight from the table. Otherwise the table is rebuilt one taxon at a time:
// an upward step to k taxa runs one multiply-add per row, a downward step one
// multiply, subtract and radix-16 divide per row. Reset is synchronous; the
// table memory needs no clearing pass, since every row is rewritten before it
// is read. One query is worked at a time; the next beat is taken while a
// finished result still waits in the output register.
module phylogenetic_tree_counter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Query channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ptc_pkg::CMD_W-1:0]     i_command,
    input  logic [ptc_pkg::TAXA_W-1:0]    i_taxa,
    input  logic [ptc_pkg::NODES_W-1:0]   i_internal_nodes,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptc_pkg::TREE_W-1:0]    o_tree_count,
    output logic [ptc_pkg::STATUS_W-1:0]  o_status
);
    import ptc_pkg::*;

    // Command and status bundles between the two halves
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: decode, rebuild walk (up with the recurrence, down with its
    // exact inverse), table read, then handoff into the output register.
    ptc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Datapath: holds the count table in a RAM, one multiply stage, the
    // saturating adders, the divider and the result registers.
    ptc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_command        (i_command),
        .i_taxa           (i_taxa),
        .i_internal_nodes (i_internal_nodes),
        .o_tree_count     (o_tree_count),
        .o_status         (o_status)
    );

endmodule

### dv/tree_count_scoreboard.sv
// Scoreboard for the tree counter: mirrors the count table and checks every result beat.
module tree_count_scoreboard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [ptc_pkg::CMD_W-1:0]     i_command,
    input  logic [ptc_pkg::TAXA_W-1:0]    i_taxa,
    input  logic [ptc_pkg::NODES_W-1:0]   i_internal_nodes,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [ptc_pkg::TREE_W-1:0]    i_tree_count,
    input  logic [ptc_pkg::STATUS_W-1:0]  i_status,
    output int                            o_errors,
    output int                            o_pending
);
    import ptc_pkg::*;

    typedef struct packed {
        logic [TREE_W-1:0] count;
        t_status           status;
    } t_tree_result;

    t_tree_result expected_counts[$];
    int           mismatch_count;

    // Mirror of the count table for the currently built taxon count
    logic [COUNT_WIDTH-1:0] row_count [MAX_TAXA];
    bit                     row_sat   [MAX_TAXA];
    int unsigned            table_taxa;

    // Saturating ops; top bit of the return flags overflow
    function automatic logic [COUNT_WIDTH:0] mul_sat(input logic [COUNT_WIDTH-1:0] a,
                                                      input int unsigned k);
        logic [2*COUNT_WIDTH-1:0] prod;
        prod = {{COUNT_WIDTH{1'b0}}, a} * (2*COUNT_WIDTH)'(k);
        if (prod[2*COUNT_WIDTH-1:COUNT_WIDTH] != '0) return {1'b1, COUNT_MAX};
        return {1'b0, prod[COUNT_WIDTH-1:0]};
    endfunction

    function automatic logic [COUNT_WIDTH:0] add_sat(input logic [COUNT_WIDTH-1:0] a,
                                                      input logic [COUNT_WIDTH-1:0] b);
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum[COUNT_WIDTH]) return {1'b1, COUNT_MAX};
        return sum;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < MAX_TAXA; i++) begin
            row_count[i] = '0;
            row_sat[i]   = 1'b0;
        end
        row_count[1] = COUNT_WIDTH'(1);
    endfunction

    // Table holds k-1 taxa, make it hold k: forward recurrence
    function automatic void grow_table(input int unsigned k);
        logic [COUNT_WIDTH-1:0] a, b, c, tot;
        logic [COUNT_WIDTH:0]   r;
        bit                     am, bm, cm, tm, tof, of;
        a   = COUNT_WIDTH'(1);
        tot = COUNT_WIDTH'(1);
        am  = 1'b0;
        tm  = 1'b0;
        tof = 1'b0;
        row_count[1] = COUNT_WIDTH'(1);
        row_sat[1]   = 1'b0;
        for (int unsigned m = 2; m < k; m++) begin
            b  = row_count[m];
            bm = row_sat[m];
            r  = mul_sat(a, k + m - 2);
            of = r[COUNT_WIDTH];
            c  = r[COUNT_WIDTH-1:0];
            cm = am;
            if (m < k - 1) begin
                r  = mul_sat(b, m);
                of = of | r[COUNT_WIDTH];
                r  = add_sat(c, r[COUNT_WIDTH-1:0]);
                of = of | r[COUNT_WIDTH];
                c  = r[COUNT_WIDTH-1:0];
                cm = cm | bm;
            end
            cm           = cm | of;
            row_count[m] = c;
            row_sat[m]   = cm;
            r   = add_sat(tot, c);
            tof = tof | r[COUNT_WIDTH];
            tot = r[COUNT_WIDTH-1:0];
            tm  = tm | cm;
            a   = b;
            am  = bm;
        end
        row_count[0] = tot;
        row_sat[0]   = tm | tof;
    endfunction

    // Table holds k taxa unsaturated, make it hold k-1: exact inverse
    function automatic void shrink_table(input int unsigned k);
        logic [COUNT_WIDTH-1:0] p, c, tot;
        logic [COUNT_WIDTH:0]   r;
        bit                     tof;
        tot = COUNT_WIDTH'(1);
        tof = 1'b0;
        row_count[1] = COUNT_WIDTH'(1);
        row_sat[1]   = 1'b0;
        for (int unsigned m = 2; m + 1 < k; m++) begin
            r = mul_sat(row_count[m - 1], m + k - 2);
            p = r[COUNT_WIDTH-1:0];
            // underflow only happens on a corrupted table: entry reads zero
            if (!r[COUNT_WIDTH] && row_count[m] >= p)
                c = (row_count[m] - p) / COUNT_WIDTH'(m);
            else
                c = '0;
            row_count[m] = c;
            row_sat[m]   = 1'b0;
            r   = add_sat(tot, c);
            tof = tof | r[COUNT_WIDTH];
            tot = r[COUNT_WIDTH-1:0];
        end
        row_count[0]     = tot;
        row_sat[0]       = tof;
        row_count[k - 1] = '0;
        row_sat[k - 1]   = 1'b0;
    endfunction

    function automatic void retarget_table(input int unsigned n);
        bit any_sat;
        any_sat = 1'b0;
        if (table_taxa == n) return;
        if (table_taxa > n && table_taxa <= MAX_TAXA)
            for (int unsigned k = 0; k < table_taxa; k++) any_sat = any_sat | row_sat[k];
        // a saturated table cannot be walked down: restart from scratch
        if (table_taxa < 3 || table_taxa > MAX_TAXA || any_sat) begin
            clear_table();
            table_taxa = 2;
        end
        if (table_taxa < n) begin
            for (int unsigned k = table_taxa + 1; k <= n; k++) begin
                row_count[k - 1] = '0;
                row_sat[k - 1]   = 1'b0;
                grow_table(k);
            end
        end else begin
            for (int unsigned k = table_taxa; k > n; k--) shrink_table(k);
        end
        table_taxa = n;
    endfunction

    function automatic t_tree_result count_query(input logic [CMD_W-1:0]   cmd,
                                                 input logic [TAXA_W-1:0]  taxa,
                                                 input logic [NODES_W-1:0] nodes);
        int unsigned  n, m, rn, idx;
        bit           unrooted, ok;
        t_tree_result res;
        n        = 32'(taxa);
        m        = 32'(nodes);
        unrooted = (cmd == CMD_UNROOTED) || (cmd == CMD_RESOLVED_UNROOTED) ||
                   (cmd == CMD_TOTAL_UNROOTED);
        ok       = (cmd <= CMD_TOTAL_UNROOTED);
        if (unrooted) begin
            ok = ok && (n >= 3);
            rn = (n >= 1) ? n - 1 : 0;
        end else begin
            ok = ok && (n >= 2);
            rn = n;
        end
        ok = ok && (rn <= MAX_TAXA);
        if (cmd == CMD_ROOTED || cmd == CMD_UNROOTED) begin
            ok  = ok && (m >= 1) && (m < rn);
            idx = m;
        end else if (cmd == CMD_RESOLVED_ROOTED || cmd == CMD_RESOLVED_UNROOTED) begin
            idx = (rn >= 1) ? rn - 1 : 0;
        end else begin
            idx = 0;
        end
        if (!ok) begin
            res.count  = '0;
            res.status = ST_INVALID;
            return res;
        end
        // two rooted taxa: one tree, table left alone
        if (rn == 2) begin
            res.count  = TREE_W'(1);
            res.status = ST_OK;
            return res;
        end
        retarget_table(rn);
        if (idx >= MAX_TAXA) idx = MAX_TAXA - 1;
        if (row_sat[idx]) begin
            res.count  = TREE_W'(COUNT_MAX);
            res.status = ST_SATURATED;
        end else begin
            res.count  = TREE_W'(row_count[idx]);
            res.status = ST_OK;
        end
        return res;
    endfunction

    initial mismatch_count = 0;

    always @(posedge i_clk) begin : watch
        t_tree_result want;
        if (!i_rst_n) begin
            clear_table();
            table_taxa = 0;
            expected_counts.delete();
        end else begin
            // result side first so a beat never matches a query taken on the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_counts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat: expected none, got count %h status %0d",
                             $time, i_tree_count, i_status);
                end else begin
                    want = expected_counts.pop_front();
                    if (i_tree_count !== want.count) begin
                        mismatch_count++;
                        $display("%0t: tree_count mismatch: expected %h, got %h",
                                 $time, want.count, i_tree_count);
                    end
                    if (i_status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_counts.insert(expected_counts.size(),
                                       count_query(i_command, i_taxa, i_internal_nodes));
        end
        o_errors  <= mismatch_count;
        o_pending <= expected_counts.size();
    end

endmodule

### dv/tb_phylogenetic_tree_counter_core.sv
// Testbench top for the tree counter: clock, reset, query stimulus, result sink and verdict.
module tb_phylogenetic_tree_counter_core;
    import ptc_pkg::*;

    // Command codes the block must reject
    localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

    localparam int PHASE_ITEMS  = 530;
    localparam int HOLD_AT      = 60;          // query index in the first phase
    localparam int HOLD_CYCLES  = 400;         // long receiver back-off
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 10_000_000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command;
    logic [TAXA_W-1:0]    i_taxa;
    logic [NODES_W-1:0]   i_internal_nodes;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [TREE_W-1:0]    o_tree_count;
    logic [STATUS_W-1:0]  o_status;

    int          sb_errors;
    int          sb_pending;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          hold_go;
    int unsigned focus_taxa;   // rooted taxon count most queries stay near
    int unsigned cycle_count;

    phylogenetic_tree_counter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_taxa           (i_taxa),
        .i_internal_nodes (i_internal_nodes),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_tree_count     (o_tree_count),
        .o_status         (o_status)
    );

    tree_count_scoreboard u_scoreboard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_taxa           (i_taxa),
        .i_internal_nodes (i_internal_nodes),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_tree_count     (o_tree_count),
        .i_status         (o_status),
        .o_errors         (sb_errors),
        .o_pending        (sb_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_phylogenetic_tree_counter_core: done, errors");
        $finish;
    end

    // Result sink: random back-pressure plus one long hold-off, counted here
    initial begin : sink
        int unsigned hold_left;
        bit          hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
            end
        end
    end

    // One query beat; valid stays up until the block takes it
    task automatic send_query(input logic [CMD_W-1:0]   cmd,
                              input logic [TAXA_W-1:0]  taxa,
                              input logic [NODES_W-1:0] nodes);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= cmd;
        i_taxa           <= taxa;
        i_internal_nodes <= nodes;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Mostly well-formed queries around a sticky taxon count so rebuilds stay
    // occasional; a slice of bad commands and wild taxon counts as noise.
    task automatic send_random_query();
        logic [CMD_W-1:0] cmd;
        int unsigned      n, m, rn;
        bit               unrooted;
        if ($urandom_range(99, 0) < 15)
            focus_taxa = $urandom_range(1, 0) ? $urandom_range(8, 3)
                                              : $urandom_range(MAX_TAXA, 2);
        if ($urandom_range(99, 0) < 8)
            cmd = $urandom_range(1, 0) ? CMD_BAD_LO : CMD_BAD_HI;
        else
            cmd = CMD_W'($urandom_range(5, 0));
        unrooted = (cmd == CMD_UNROOTED) || (cmd == CMD_RESOLVED_UNROOTED) ||
                   (cmd == CMD_TOTAL_UNROOTED);
        n = unrooted ? focus_taxa + 1 : focus_taxa;
        if ($urandom_range(99, 0) < 8) n = $urandom_range(31, 0);
        rn = unrooted ? ((n >= 1) ? n - 1 : 0) : n;
        if ((cmd == CMD_ROOTED || cmd == CMD_UNROOTED) && rn >= 2 && rn <= MAX_TAXA &&
            $urandom_range(99, 0) >= 10)
            m = $urandom_range(rn - 1, 1);
        else
            m = $urandom_range(15, 0);
        send_query(cmd, TAXA_W'(n), NODES_W'(m));
    endtask

    // Sender stops and waits for every outstanding result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb_pending != 0);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = '0;
        i_taxa           = '0;
        i_internal_nodes = '0;
        hold_go          = 1'b0;
        tx_idle_pct      = 21;
        rx_idle_pct      = 47;
        focus_taxa       = 4;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: trivial cases, the full-size table, a long shrink, bad arguments
        send_query(CMD_RESOLVED_ROOTED,   5'd2,  4'd0);
        send_query(CMD_RESOLVED_UNROOTED, 5'd3,  4'd15);
        send_query(CMD_ROOTED,            5'd2,  4'd1);
        send_query(CMD_TOTAL_ROOTED,      5'd16, 4'd0);
        send_query(CMD_ROOTED,            5'd16, 4'd15);
        send_query(CMD_ROOTED,            5'd16, 4'd1);
        send_query(CMD_ROOTED,            5'd16, 4'd8);
        send_query(CMD_RESOLVED_ROOTED,   5'd16, 4'd7);
        send_query(CMD_UNROOTED,          5'd17, 4'd15);
        send_query(CMD_RESOLVED_UNROOTED, 5'd17, 4'd0);
        send_query(CMD_TOTAL_UNROOTED,    5'd17, 4'd0);
        send_query(CMD_TOTAL_ROOTED,      5'd3,  4'd0);
        send_query(CMD_ROOTED,            5'd5,  4'd3);
        send_query(CMD_BAD_LO,            5'd5,  4'd2);
        send_query(CMD_BAD_HI,            5'd31, 4'd15);
        send_query(CMD_ROOTED,            5'd16, 4'd0);
        send_query(CMD_ROOTED,            5'd5,  4'd5);
        send_query(CMD_TOTAL_ROOTED,      5'd1,  4'd0);
        send_query(CMD_TOTAL_ROOTED,      5'd0,  4'd0);
        send_query(CMD_TOTAL_UNROOTED,    5'd2,  4'd0);
        send_query(CMD_UNROOTED,          5'd18, 4'd1);
        send_query(CMD_RESOLVED_ROOTED,   5'd17, 4'd0);
        send_query(CMD_TOTAL_UNROOTED,    5'd31, 4'd0);
        send_query(CMD_UNROOTED,          5'd10, 4'd4);
        send_query(CMD_TOTAL_UNROOTED,    5'd9,  4'd0);
        wait_drained();

        // Random phases: sender-light, receiver-light, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 21;
                    rx_idle_pct <= 47;
                end
                1: begin
                    tx_idle_pct = 47;
                    rx_idle_pct <= 21;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // receiver backs off while queries keep coming, so the block fills up
                if (phase == 0 && i == HOLD_AT) hold_go <= 1'b1;
                send_random_query();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb_errors == 0)
            $display("tb_phylogenetic_tree_counter_core: done, clean");
        else
            $display("tb_phylogenetic_tree_counter_core: done, errors");
        $finish;
    end

endmodule
